### src/timestamped_multi_writer_register_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timestamped multi-writer register
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_MULTI_WRITER_REGISTER_TOP_DEFINES_SVH
`define TIMESTAMPED_MULTI_WRITER_REGISTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define TMWR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TMWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/tmwr_pkg.sv
// ----------------------------------------------------------------------------
// tmwr_pkg
// Constants and types shared by the register table cells and the top level.
// ----------------------------------------------------------------------------
package tmwr_pkg;

  localparam int ENTRIES    = 8;
  localparam int STAMP_BITS = 32;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int VALUE_W    = 32;
  localparam int WRITER_W   = 3;
  localparam int OUT_STAMP_W = 32;

  localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};
  localparam logic [63:0] STAMP_MAX_WIDE = 64'(STAMP_MAX);
  localparam logic [OUT_STAMP_W-1:0] OUT_STAMP_MAX = STAMP_MAX_WIDE[OUT_STAMP_W-1:0];

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic                  vld;
    logic [STAMP_BITS-1:0] stamp;
    logic [VALUE_W-1:0]    value;
    logic [IDX_W-1:0]      idx;
  } link_t;

  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      idx;
    logic [STAMP_BITS-1:0] stamp;
    logic [VALUE_W-1:0]    value;
  } wr_t;

endpackage

### src/tmwr_cell.sv
// ----------------------------------------------------------------------------
// tmwr_cell
// One table entry: holds its stamp and value, and passes the running
// greatest-stamp candidate on to the next cell through its output register.
// ----------------------------------------------------------------------------
module tmwr_cell
  import tmwr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [IDX_W-1:0]   cell_idx,
  input  logic [VALUE_W-1:0] init_value,
  input  wr_t                wr,
  input  link_t              link_in,
  output link_t              link_out
);

  logic [STAMP_BITS-1:0] stamp;
  logic [VALUE_W-1:0]    value;
  logic                  written;
  logic [VALUE_W-1:0]    my_value;
  logic                  hit;

  assign my_value = written ? value : init_value;
  assign hit      = wr.en && (wr.idx == cell_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp   <= '0;
      written <= 1'b0;
    end else if (hit) begin
      stamp   <= wr.stamp;
      written <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      value <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.vld <= 1'b0;
    end else begin
      link_out.vld <= link_in.vld;
    end
    if (stamp >= link_in.stamp) begin
      link_out.stamp <= stamp;
      link_out.value <= my_value;
      link_out.idx   <= cell_idx;
    end else begin
      link_out.stamp <= link_in.stamp;
      link_out.value <= link_in.value;
      link_out.idx   <= link_in.idx;
    end
  end

endmodule

### src/timestamped_multi_writer_register_top.sv
// ----------------------------------------------------------------------------
// timestamped_multi_writer_register_top
// Per-writer stamp table that behaves as one atomic register.
// ----------------------------------------------------------------------------
// An operation word enters on the s_axis channel: tuser carries the opcode
// (read or write), tdata the writer index and the value to write. Each word
// yields one result word on m_axis with the value and stamp of the entry
// holding the greatest stamp after the operation, ties going to the higher
// index, and a flag when a write found the stamp already at its maximum.
// The initial value of unwritten entries is set on the cfg channel, which
// is always ready and should be written only while no operation is open.
// The table is a row of ENTRIES cells; a candidate walks through them one
// cell per cycle. As the result leaves the last cell it is loaded into the
// output register, or into a hold register while that one is full. A new
// word is taken only after the scan ends. One operation is open at a time.
// The result sits in an output register; if the receiver stalls, a finished
// result is held and no new word is taken until that register frees up.
// Reset clears all stamps, marks every entry unwritten and sets the
// initial value to zero.
// ----------------------------------------------------------------------------
`include "timestamped_multi_writer_register_top_defines.svh"

module timestamped_multi_writer_register_top
  import tmwr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // writer_id[2:0], write_value[34:3], zero
  input  logic [0:0]  s_axis_tuser,   // opcode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // current_value[31:0], current_stamp[63:32],
                                      // stamp_saturated[64], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data        // initial_value
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]          state;
  logic                start;
  logic [VALUE_W-1:0]  init_value;
  logic                op;
  logic [WRITER_W-1:0] writer_id;
  logic [VALUE_W-1:0]  write_value;

  link_t               links [ENTRIES+1];
  logic [ENTRIES:0]    link_vld;
  wr_t                 wr;
  link_t               tail;

  logic                in_acc;
  logic                slot_free;
  logic                load_out;
  logic                in_range;
  logic                do_wr;
  logic                top_sat;
  logic [IDX_W-1:0]    wr_idx;

  logic [VALUE_W-1:0]     res_value;
  logic [STAMP_BITS-1:0]  res_stamp;
  logic                   res_sat;
  logic [63:0]            res_stamp_wide;
  logic [VALUE_W-1:0]     hold_value;
  logic [OUT_STAMP_W-1:0] hold_stamp;
  logic                   hold_sat;

  logic                   out_valid;
  logic [VALUE_W-1:0]     out_value;
  logic [OUT_STAMP_W-1:0] out_stamp;
  logic                   out_sat;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_sat, out_stamp, out_value};
  assign slot_free     = !out_valid || m_axis_tready;
  assign load_out      = slot_free && ((state == ST_SCAN && tail.vld) || state == ST_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      init_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      init_value <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op          <= s_axis_tuser[0];
      writer_id   <= s_axis_tdata[2:0];
      write_value <= s_axis_tdata[34:3];
    end
  end

  // The seed loses to cell 0 on any stamp, since ties go to the cell.
  always_comb begin
    links[0].vld   = start;
    links[0].stamp = '0;
    links[0].value = '0;
    links[0].idx   = '0;
  end

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      tmwr_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cell_idx   (IDX_W'(g)),
        .init_value (init_value),
        .wr         (wr),
        .link_in    (links[g]),
        .link_out   (links[g+1])
      );
    end
    for (g = 0; g <= ENTRIES; g++) begin : g_vld
      assign link_vld[g] = links[g].vld;
    end
  endgenerate

  assign tail     = links[ENTRIES];
  assign in_range = (32'(writer_id) < 32'(ENTRIES));
  assign do_wr    = (op == OP_WRITE) && in_range;
  assign top_sat  = (tail.stamp == STAMP_MAX);
  assign wr_idx   = IDX_W'(writer_id);

  always_comb begin
    wr.en    = (state == ST_SCAN) && tail.vld && do_wr;
    wr.idx   = wr_idx;
    wr.stamp = top_sat ? STAMP_MAX : tail.stamp + STAMP_BITS'(1);
    wr.value = write_value;
  end

  // When saturated, the writer joins the tie at the maximum stamp and wins
  // only if its index is not below the current winner.
  always_comb begin
    res_value = tail.value;
    res_stamp = tail.stamp;
    res_sat   = 1'b0;
    if (do_wr) begin
      res_stamp = wr.stamp;
      res_sat   = top_sat;
      if (!top_sat || (wr_idx >= tail.idx)) begin
        res_value = write_value;
      end
    end
  end

  assign res_stamp_wide = 64'(res_stamp);

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && tail.vld) begin
      hold_value <= res_value;
      hold_stamp <= res_stamp_wide[OUT_STAMP_W-1:0];
      hold_sat   <= res_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && state == ST_SCAN && tail.vld) begin
      out_value <= res_value;
      out_stamp <= res_stamp_wide[OUT_STAMP_W-1:0];
      out_sat   <= res_sat;
    end else if (slot_free && state == ST_HOLD) begin
      out_value <= hold_value;
      out_stamp <= hold_stamp;
      out_sat   <= hold_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      start <= in_acc;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail.vld) begin
            if (slot_free) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TMWR_ASSERT_NOW(a_one_candidate, 1'b1, $countones(link_vld) <= 1, "two candidates in row")
  `TMWR_ASSERT_NOW(a_tail_in_scan, tail.vld, state == ST_SCAN, "candidate outside a scan")
  `TMWR_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready && start, "scan not started")
  `TMWR_ASSERT_NOW(a_sat_stamp, out_valid && out_sat, out_stamp == OUT_STAMP_MAX, "bad sat stamp")

endmodule

### dv/timestamped_multi_writer_register_top_tb.sv
// ----------------------------------------------------------------------------
// Testbench for timestamped_multi_writer_register_top
// Streams read and write words through the stamp table, predicts the winning
// entry for every word in a scoreboard, and checks each result word field by
// field. Both stream sides idle at random, the receiver once holds off long
// enough to stall the input, and the initial value is changed between phases.
// ----------------------------------------------------------------------------
module timestamped_multi_writer_register_top_tb
  import tmwr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [VALUE_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] INT_MAX = 32'h7fff_ffff;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 300;

  typedef struct {
    logic [VALUE_W-1:0]     value;
    logic [OUT_STAMP_W-1:0] stamp;
    logic                   saturated;
  } outcome_t;

  class stamp_table;
    logic [STAMP_BITS-1:0] stamps[ENTRIES];
    logic [VALUE_W-1:0]    values[ENTRIES];
    bit                    written[ENTRIES];
    logic [VALUE_W-1:0]    init_value;
    outcome_t              outcome_q[$];
    int                    mismatches;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        stamps[i] = '0;
        values[i] = '0;
        written[i] = 1'b0;
      end
      init_value = '0;
      mismatches = 0;
    endfunction

    function int greatest();
      int best;
      logic [STAMP_BITS-1:0] best_stamp;
      best = 0;
      best_stamp = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (stamps[i] >= best_stamp) begin
          best_stamp = stamps[i];
          best = i;
        end
      end
      return best;
    endfunction

    function void set_initial_value(logic [VALUE_W-1:0] v);
      init_value = v;
    endfunction

    function void apply_op(logic op, logic [WRITER_W-1:0] wid, logic [VALUE_W-1:0] wval);
      logic [STAMP_BITS-1:0] top;
      int win;
      outcome_t o;
      o.saturated = 1'b0;
      if (op == OP_WRITE && int'(wid) < ENTRIES) begin
        top = stamps[greatest()];
        if (top == STAMP_MAX) begin
          o.saturated = 1'b1;
        end else begin
          top = top + 1'b1;
        end
        stamps[wid] = top;
        values[wid] = wval;
        written[wid] = 1'b1;
      end
      win = greatest();
      o.value = written[win] ? values[win] : init_value;
      o.stamp = OUT_STAMP_W'(stamps[win]);
      outcome_q.push_back(o);
    endfunction

    function void compare_result(logic [71:0] word);
      outcome_t got;
      outcome_t want;
      got.value = word[31:0];
      got.stamp = word[63:32];
      got.saturated = word[64];
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: value %0d stamp %0d saturated %0b",
                   $signed(got.value), got.stamp, got.saturated);
        return;
      end
      want = outcome_q.pop_front();
      if (got.value !== want.value || got.stamp !== want.stamp ||
          got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected value %0d stamp %0d saturated %0b,",
                    " got value %0d stamp %0d saturated %0b"},
                   $signed(want.value), want.stamp, want.saturated,
                   $signed(got.value), got.stamp, got.saturated);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // writer_id[2:0], write_value[34:3], zero
  logic [0:0]  s_axis_tuser = '0;   // opcode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // current_value[31:0], current_stamp[63:32],
                                    // stamp_saturated[64], zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;       // initial_value

  stamp_table board = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;

  timestamped_multi_writer_register_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_initial_value(cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        board.apply_op(s_axis_tuser[0], s_axis_tdata[2:0], s_axis_tdata[34:3]);
      if (m_axis_tvalid && m_axis_tready) board.compare_result(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The long hold-off is timed here so the sender keeps offering words meanwhile.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_op(input logic op, input logic [WRITER_W-1:0] wid,
                         input logic [VALUE_W-1:0] wval);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {5'b0, wval, wid};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic finish_burst();
    s_axis_tvalid <= 1'b0;
    while (board.outcome_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
  endtask

  task automatic set_initial(input logic [VALUE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_burst(input int count);
    for (int n = 0; n < count; n++)
      send_op($urandom_range(0, 1) ? OP_WRITE : OP_READ,
              WRITER_W'($urandom_range(0, ENTRIES - 1)), pick_value());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Before any write the last entry wins with the initial value.
    send_op(OP_READ, 3'd0, '0);
    finish_burst();
    set_initial(INT_MIN);
    send_op(OP_READ, 3'd7, INT_MAX);
    finish_burst();
    set_initial(INT_MAX);
    send_op(OP_READ, 3'd3, 32'h5555_5555);
    finish_burst();
    set_initial('1);
    send_op(OP_READ, 3'd5, '1);
    send_op(OP_WRITE, 3'd0, INT_MIN);
    send_op(OP_READ, 3'd7, '0);
    send_op(OP_WRITE, 3'd7, INT_MAX);
    send_op(OP_WRITE, 3'd3, '0);
    send_op(OP_WRITE, 3'd3, '1);
    send_op(OP_READ, 3'd0, 32'h1234_5678);
    send_op(OP_WRITE, 3'd5, 32'h5555_5555);
    send_op(OP_WRITE, 3'd2, 32'haaaa_aaaa);
    send_op(OP_WRITE, 3'd1, 32'd1);
    send_op(OP_WRITE, 3'd4, 32'hffff_fffe);
    send_op(OP_WRITE, 3'd6, 32'h8000_0001);
    send_op(OP_READ, 3'd6, '0);
    send_op(OP_WRITE, 3'd0, 32'h7fff_fffe);
    send_op(OP_READ, 3'd1, INT_MIN);
    finish_burst();

    send_idle_pct = 10;
    recv_idle_pct = 85;
    random_burst(PHASE_ITEMS);
    finish_burst();
    set_initial($urandom);

    send_idle_pct = 85;
    recv_idle_pct = 10;
    random_burst(PHASE_ITEMS);
    finish_burst();
    set_initial(INT_MIN);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    random_burst(PHASE_ITEMS);
    finish_burst();

    if (board.mismatches == 0 && board.outcome_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
